### src/brp_pkg.sv
`default_nettype none

package brp_pkg;

    // Widths of the item fields
    localparam int DATA_W          = 64;
    localparam int CHAR_W          = 8;
    localparam int POS_W           = 3;
    localparam int BRP_VALUE_BITS  = 64;

    // Prefix "bytes=" is six characters long
    localparam logic [POS_W-1:0] PREFIX_LEN = 3'd6;

    // Characters of interest after the prefix
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    // Result status codes
    typedef enum logic [1:0] {
        ST_ABSENT  = 2'd0,
        ST_VALID   = 2'd1,
        ST_INVALID = 2'd2
    } t_brp_status;

    // One input item: a header character
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              is_last;
        logic              value_absent;
        logic [DATA_W-1:0] rsrc_size;
    } t_brp_in;

    // One result item
    typedef struct packed {
        t_brp_status       status;
        logic [DATA_W-1:0] first_byte;
        logic [DATA_W-1:0] last_byte;
    } t_brp_out;

    // Parser state captured at the last character, handed to the judge stage
    typedef struct packed {
        logic [POS_W-1:0]  prefix_pos;
        logic              dash_seen;
        logic              bad_flag;
        logic              start_has_digits;
        logic              stop_has_digits;
        logic [DATA_W-1:0] start_value;
        logic [DATA_W-1:0] stop_value;
        logic [DATA_W-1:0] rsrc_size;
    } t_brp_snap;

    // Expected character at each prefix position
    function automatic logic [CHAR_W-1:0] prefix_char(input logic [POS_W-1:0] pos);
        logic [CHAR_W-1:0] c;
        unique case (pos)
            3'd0:    c = 8'h62; // b
            3'd1:    c = 8'h79; // y
            3'd2:    c = 8'h74; // t
            3'd3:    c = 8'h65; // e
            3'd4:    c = 8'h73; // s
            3'd5:    c = 8'h3D; // =
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### src/brp_scan.sv
`default_nettype none

module brp_scan #(
    parameter int VALUE_BITS = brp_pkg::BRP_VALUE_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire brp_pkg::t_brp_in    i_in_item,
    output logic                     o_snap_valid,
    input  wire logic                i_snap_stall,
    output brp_pkg::t_brp_snap       o_snap
);
    import brp_pkg::*;

    localparam int WIDE_W = VALUE_BITS + 4;

    // Input register
    logic                  r_in_vld;
    t_brp_in               r_in;

    // Parser state
    logic [POS_W-1:0]      r_prefix_pos, n_prefix_pos;
    logic                  r_dash_seen, n_dash_seen;
    logic                  r_bad_flag, n_bad_flag;
    logic [VALUE_BITS-1:0] r_start_value, n_start_value;
    logic                  r_start_has, n_start_has;
    logic [VALUE_BITS-1:0] r_stop_value, n_stop_value;
    logic                  r_stop_has, n_stop_has;

    // Snapshot register
    logic                  r_snap_vld;
    t_brp_snap             r_snap;

    logic                  w_snap_free;
    logic                  w_proc;
    logic [VALUE_BITS-1:0] w_acc;
    logic [WIDE_W-1:0]     w_wide;
    logic                  w_ovf;
    logic                  w_digit;

    // Handshake: a last item needs a free snapshot slot
    assign w_snap_free  = !r_snap_vld || !i_snap_stall;
    assign w_proc       = r_in_vld && (!r_in.is_last || w_snap_free);
    assign o_in_stall   = r_in_vld && !w_proc;
    assign o_snap_valid = r_snap_vld;
    assign o_snap       = r_snap;

    // Shared decimal accumulate: acc * 10 + digit, overflow if upper bits set
    assign w_acc   = r_dash_seen ? r_stop_value : r_start_value;
    assign w_wide  = (WIDE_W'(w_acc) << 3) + (WIDE_W'(w_acc) << 1)
                   + WIDE_W'(r_in.ch[3:0]);
    assign w_ovf   = |w_wide[WIDE_W-1:VALUE_BITS];
    assign w_digit = (r_in.ch >= CH_ZERO) && (r_in.ch <= CH_NINE);

    // Next parser state for the item held in the input register
    always_comb begin
        n_prefix_pos  = r_prefix_pos;
        n_dash_seen   = r_dash_seen;
        n_bad_flag    = r_bad_flag;
        n_start_value = r_start_value;
        n_start_has   = r_start_has;
        n_stop_value  = r_stop_value;
        n_stop_has    = r_stop_has;
        if (!r_in.value_absent) begin
            priority if (r_prefix_pos < PREFIX_LEN) begin
                if (r_in.ch == prefix_char(r_prefix_pos)) begin
                    n_prefix_pos = r_prefix_pos + 3'd1;
                end else begin
                    n_bad_flag = 1'b1;
                end
            end else if (r_in.ch == CH_DASH) begin
                if (r_dash_seen) begin
                    n_bad_flag = 1'b1;
                end
                n_dash_seen = 1'b1;
            end else if (w_digit) begin
                if (w_ovf) begin
                    n_bad_flag = 1'b1;
                end
                if (r_dash_seen) begin
                    if (!w_ovf) begin
                        n_stop_value = w_wide[VALUE_BITS-1:0];
                    end
                    n_stop_has = 1'b1;
                end else begin
                    if (!w_ovf) begin
                        n_start_value = w_wide[VALUE_BITS-1:0];
                    end
                    n_start_has = 1'b1;
                end
            end else if (r_in.ch == CH_COMMA) begin
                n_bad_flag = 1'b1;
            end else begin
                n_bad_flag = 1'b1;
            end
        end
    end

    // Input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!r_in_vld || w_proc) begin
            r_in_vld <= i_in_valid;
        end
    end

    // Input register payload
    always_ff @(posedge i_clk) begin
        if (!r_in_vld || w_proc) begin
            r_in <= i_in_item;
        end
    end

    // Parser state: cleared after every last item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_proc && r_in.is_last)) begin
            r_prefix_pos  <= '0;
            r_dash_seen   <= 1'b0;
            r_bad_flag    <= 1'b0;
            r_start_value <= '0;
            r_start_has   <= 1'b0;
            r_stop_value  <= '0;
            r_stop_has    <= 1'b0;
        end else if (w_proc) begin
            r_prefix_pos  <= n_prefix_pos;
            r_dash_seen   <= n_dash_seen;
            r_bad_flag    <= n_bad_flag;
            r_start_value <= n_start_value;
            r_start_has   <= n_start_has;
            r_stop_value  <= n_stop_value;
            r_stop_has    <= n_stop_has;
        end
    end

    // Snapshot valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_vld <= 1'b0;
        end else if (w_snap_free) begin
            r_snap_vld <= w_proc && r_in.is_last;
        end
    end

    // Snapshot payload
    always_ff @(posedge i_clk) begin
        if (w_proc && r_in.is_last) begin
            r_snap.prefix_pos       <= n_prefix_pos;
            r_snap.dash_seen        <= n_dash_seen;
            r_snap.bad_flag         <= n_bad_flag;
            r_snap.start_has_digits <= n_start_has;
            r_snap.stop_has_digits  <= n_stop_has;
            r_snap.start_value      <= DATA_W'(n_start_value);
            r_snap.stop_value       <= DATA_W'(n_stop_value);
            r_snap.rsrc_size        <= r_in.rsrc_size;
        end
    end

    // State is clear after a last item
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc && r_in.is_last |=> r_prefix_pos == '0 && !r_dash_seen && !r_bad_flag
                                   && !r_start_has && !r_stop_has)
        else $error("parser state not cleared after last item");

    // Prefix position never passes the prefix length
    a_prefix_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prefix_pos <= PREFIX_LEN)
        else $error("prefix position out of range");

    // Digits are only collected after a complete prefix, end digits after a dash
    a_digits_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_start_has || r_stop_has) |-> r_prefix_pos == PREFIX_LEN
                                        && (!r_stop_has || r_dash_seen))
        else $error("digits collected out of order");

endmodule

`default_nettype wire

### src/brp_judge.sv
`default_nettype none

module brp_judge (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_snap_valid,
    output logic                     o_snap_stall,
    input  wire brp_pkg::t_brp_snap  i_snap,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output brp_pkg::t_brp_out        o_out_item
);
    import brp_pkg::*;

    logic              r_out_vld;
    t_brp_out          r_out;
    t_brp_out          n_out;

    logic [DATA_W-1:0] w_fs_m1;
    logic [DATA_W-1:0] w_fs_less_stop;
    logic              w_stop_lt_fs;
    logic              w_stop_lt_fs_m1;
    logic              w_start_ge_fs;
    logic              w_stop_lt_start;

    // Side computations, all in parallel
    assign w_fs_m1         = i_snap.rsrc_size - DATA_W'(1);
    assign w_fs_less_stop  = i_snap.rsrc_size - i_snap.stop_value;
    assign w_stop_lt_fs    = i_snap.stop_value < i_snap.rsrc_size;
    assign w_stop_lt_fs_m1 = i_snap.stop_value < w_fs_m1;
    assign w_start_ge_fs   = i_snap.start_value >= i_snap.rsrc_size;
    assign w_stop_lt_start = i_snap.stop_value < i_snap.start_value;

    // Verdict on the captured header
    always_comb begin
        n_out.status     = ST_INVALID;
        n_out.first_byte = '0;
        n_out.last_byte  = '0;
        priority if (i_snap.prefix_pos == '0 && !i_snap.bad_flag) begin
            n_out.status = ST_ABSENT;
        end else if (i_snap.bad_flag || i_snap.prefix_pos != PREFIX_LEN
                     || !i_snap.dash_seen || i_snap.rsrc_size == '0) begin
            n_out.status = ST_INVALID;
        end else if (!i_snap.start_has_digits) begin
            // suffix form: final min(N, size) bytes
            if (!i_snap.stop_has_digits || i_snap.stop_value == '0) begin
                n_out.status = ST_INVALID;
            end else begin
                n_out.status     = ST_VALID;
                n_out.first_byte = w_stop_lt_fs ? w_fs_less_stop : '0;
                n_out.last_byte  = w_fs_m1;
            end
        end else if (w_start_ge_fs) begin
            n_out.status = ST_INVALID;
        end else if (i_snap.stop_has_digits && w_stop_lt_start) begin
            n_out.status = ST_INVALID;
        end else begin
            // end clamped to size-1, open end runs to size-1
            n_out.status     = ST_VALID;
            n_out.first_byte = i_snap.start_value;
            n_out.last_byte  = (i_snap.stop_has_digits && w_stop_lt_fs_m1)
                             ? i_snap.stop_value : w_fs_m1;
        end
    end

    assign o_snap_stall = r_out_vld && i_out_stall;
    assign o_out_valid  = r_out_vld;
    assign o_out_item   = r_out;

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!o_snap_stall) begin
            r_out_vld <= i_snap_valid;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (!o_snap_stall && i_snap_valid) begin
            r_out <= n_out;
        end
    end

    // A valid range is never reversed
    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.status == ST_VALID |-> r_out.first_byte <= r_out.last_byte)
        else $error("valid range with first beyond last");

    // Offsets are zero unless the range is valid
    a_zero_offsets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.status != ST_VALID |-> r_out.first_byte == '0
                                                  && r_out.last_byte == '0)
        else $error("offsets set on a non-valid result");

    // A valid range lies inside the resource
    a_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_snap_valid && !o_snap_stall && n_out.status == ST_VALID
        |-> n_out.last_byte < i_snap.rsrc_size)
        else $error("range end beyond resource size");

endmodule

`default_nettype wire

### src/http_byte_range_parser.sv
`default_nettype none

// Single byte-range parser for an HTTP Range header value.
// Input channel: one header character per item (i_in_item), with is_last on
// the final character and value_absent for an empty value. rsrc_size is read
// on the last item only. Output channel: one result item per header, carrying
// status (absent, valid, invalid) and the inclusive first/last byte offsets.
// Both channels use valid/stall; an item moves when valid is high and stall
// is low.
// Throughput: one character per cycle, sustained, across header boundaries,
// while the receiver does not stall. The result for a header passes through
// the input register, snapshot register and result register before it is
// presented on o_out_valid; the digit accumulate and the range check each
// fit in one of those register-to-register steps.
// Reset (i_rst_n low at a clock edge) empties all stages and clears the
// parser state. When the receiver stalls, the result register holds; the
// snapshot and input registers keep filling and o_in_stall rises only when a
// last character finds both the snapshot and result registers occupied.
// Ordinary characters are still taken while a result waits.
module http_byte_range_parser #(
    parameter int VALUE_BITS = brp_pkg::BRP_VALUE_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire brp_pkg::t_brp_in   i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output brp_pkg::t_brp_out       o_out_item
);
    import brp_pkg::*;

    logic      w_snap_valid;
    logic      w_snap_stall;
    t_brp_snap w_snap;

    // Character scan and parser state
    brp_scan #(
        .VALUE_BITS (VALUE_BITS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .o_snap_valid (w_snap_valid),
        .i_snap_stall (w_snap_stall),
        .o_snap       (w_snap)
    );

    // Range check and result register
    brp_judge u_judge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (w_snap_valid),
        .o_snap_stall (w_snap_stall),
        .i_snap       (w_snap),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_item   (o_out_item)
    );

endmodule

`default_nettype wire
